@@ rtl/pfrb_pkg.sv @@
// ----------------------------------------------------------------------------
// pfrb_pkg
// types and constants shared by the packet framer ring buffer
// ----------------------------------------------------------------------------
package pfrb_pkg;

    // item kinds on the input channel
    localparam logic [1:0] KIND_START   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_HEADER = 2'd0;
    localparam logic [1:0] CFG_FOOTER = 2'd1;

    // configuration reset values
    localparam logic [7:0] HEADER_RESET = 8'd126;
    localparam logic [7:0] FOOTER_RESET = 8'd127;

    // bytes of framing around the payload
    localparam logic [8:0] FRAME_OVERHEAD = 9'd6;

    // largest value shown on the peak output
    localparam logic [7:0] PEAK_MAX = 8'hFF;

    // input word
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] packet_type;
        logic [7:0]  payload_length;
        logic [7:0]  payload_byte;
    } pfrb_in_t;

    // result word
    typedef struct packed {
        logic        accepted;
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        sending;
        logic [15:0] drop_total;
        logic [7:0]  peak_fill;
    } pfrb_out_t;

endpackage

@@ rtl/packet_framer_ring_buffer_top.sv @@
// ----------------------------------------------------------------------------
// packet_framer_ring_buffer_top
// transmit framer writing framed packets into a byte ring memory
// ----------------------------------------------------------------------------
// usage
// - input channel (in_valid/in_ready/in_data) takes one word per item: a
//   packet start, a payload byte or a line ready tick
// - output channel (out_valid/out_ready/out_data) gives one result word per
//   input word, in order, via the stage behind the memory and output register
// - config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) sets the header
//   and footer marker bytes; always ready, write only while idle
// - throughput is set by the single write port of the ring memory: in_ready
//   is low while an accepted start's remaining framing bytes, or the checksum
//   and footer after the last payload byte, are written; other items are not held
// - a tick reads the ring memory through a registered read port; the read
//   data joins the rest of the result in the stage behind the memory
// - a stalled receiver first fills the output register, then the stage
//   behind the memory, after which in_ready drops
// - reset clears pointers, counters and frame state; ring contents are not
//   cleared, as only written entries are ever read
// ----------------------------------------------------------------------------
module packet_framer_ring_buffer_top #(
    parameter int RING_DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pfrb_pkg::pfrb_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output pfrb_pkg::pfrb_out_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = ((AW > 9) ? AW : 9) + 1;
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(RING_DEPTH);
    localparam logic [CW-1:0] FREE_MAX = CW'(RING_DEPTH - 1);
    localparam int PEND = 5;

    // pointer advance with wrap at the ring depth
    function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] p, input logic [2:0] k);
        logic [AW:0] s;
        s = {1'b0, p} + (AW + 1)'(k);
        if (s >= DEPTH_W)
        begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    // occupancy between write and read pointers
    function automatic logic [AW-1:0] ring_used(input logic [AW-1:0] w, input logic [AW-1:0] r);
        logic [AW:0] s;
        if (w >= r)
        begin
            s = {1'b0, w} - {1'b0, r};
        end
        else
        begin
            s = {1'b0, w} + DEPTH_W - {1'b0, r};
        end
        return s[AW-1:0];
    endfunction

    // ring memory
    logic [7:0] ring_mem [RING_DEPTH];
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [7:0]     mem_wdata;
    logic           mem_re;
    logic [7:0]     rdata_reg;

    // control state
    logic [AW-1:0]  wp_reg, wp_next;
    logic [AW-1:0]  rp_reg, rp_next;
    logic [7:0]     sum_reg, sum_next;
    logic [7:0]     left_reg, left_next;
    logic           open_reg, open_next;
    logic           disc_reg, disc_next;
    logic [15:0]    drop_reg, drop_next;
    logic [AW-1:0]  peak_reg, peak_next;
    logic [7:0]     header_reg, footer_reg;

    // write sequencer
    logic [7:0]     pend_reg [PEND];
    logic [7:0]     pend_next [PEND];
    logic [2:0]     pcnt_reg, pcnt_next;
    logic [AW-1:0]  saddr_reg, saddr_next;
    logic           busy;

    // result stages
    logic              s1_valid_reg;
    pfrb_pkg::pfrb_out_t s1_reg, s1_next;
    pfrb_pkg::pfrb_out_t s1_join;
    logic              out_valid_reg;
    pfrb_pkg::pfrb_out_t out_reg;
    logic              s1_adv;
    logic              in_acc;

    // item decode
    logic [AW-1:0]  used_now;
    logic [CW-1:0]  room_avail;
    logic [CW-1:0]  required;
    logic [7:0]     ptype_hi, ptype_lo;
    logic [7:0]     first_byte;
    logic           first_we;
    logic           closing;
    logic [AW-1:0]  used_new;
    logic [CW-1:0]  peak_ext;

    assign busy      = (pcnt_reg != 3'd0);
    assign s1_adv    = !out_valid_reg || out_ready;
    assign in_ready  = !busy && (!s1_valid_reg || s1_adv);
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign used_now   = ring_used(wp_reg, rp_reg);
    assign room_avail = FREE_MAX - CW'(used_now);
    assign required   = CW'(in_data.payload_length) + CW'(pfrb_pkg::FRAME_OVERHEAD);
    assign ptype_hi   = in_data.packet_type[15:8];
    assign ptype_lo   = in_data.packet_type[7:0];

    // item processing: state update, bytes to write, result fields
    always_comb
    begin
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        sum_next   = sum_reg;
        left_next  = left_reg;
        open_next  = open_reg;
        disc_next  = disc_reg;
        drop_next  = drop_reg;
        peak_next  = peak_reg;
        first_we   = 1'b0;
        first_byte = in_data.payload_byte;
        closing    = 1'b0;
        mem_re     = 1'b0;
        pcnt_next  = busy ? (pcnt_reg - 3'd1) : 3'd0;
        saddr_next = busy ? ptr_add(saddr_reg, 3'd1) : saddr_reg;
        for (int i = 0; i < PEND - 1; i++)
        begin
            pend_next[i] = pend_reg[i + 1];
        end
        pend_next[PEND - 1] = pend_reg[PEND - 1];
        s1_next = '0;

        if (in_acc)
        begin
            case (in_data.kind)
                pfrb_pkg::KIND_START:
                begin
                    if (open_reg || (room_avail < required))
                    begin
                        drop_next = drop_reg + 16'd1;
                        if (!open_reg)
                        begin
                            left_next = in_data.payload_length;
                            disc_next = (in_data.payload_length != 8'd0);
                        end
                    end
                    else
                    begin
                        s1_next.accepted = 1'b1;
                        disc_next  = 1'b0;
                        first_we   = 1'b1;
                        first_byte = header_reg;
                        sum_next   = in_data.payload_length + ptype_hi + ptype_lo;
                        left_next  = in_data.payload_length;
                        saddr_next = ptr_add(wp_reg, 3'd1);
                        pend_next[0] = in_data.payload_length;
                        pend_next[1] = ptype_hi;
                        pend_next[2] = ptype_lo;
                        pend_next[3] = sum_next;
                        pend_next[4] = footer_reg;
                        if (in_data.payload_length == 8'd0)
                        begin
                            open_next = 1'b0;
                            closing   = 1'b1;
                            pcnt_next = 3'd5;
                            wp_next   = ptr_add(wp_reg, 3'd6);
                        end
                        else
                        begin
                            open_next = 1'b1;
                            pcnt_next = 3'd3;
                            wp_next   = ptr_add(wp_reg, 3'd4);
                        end
                    end
                end
                pfrb_pkg::KIND_PAYLOAD:
                begin
                    if (open_reg)
                    begin
                        first_we   = 1'b1;
                        sum_next   = sum_reg + in_data.payload_byte;
                        left_next  = left_reg - 8'd1;
                        saddr_next = ptr_add(wp_reg, 3'd1);
                        pend_next[0] = sum_next;
                        pend_next[1] = footer_reg;
                        if (left_next == 8'd0)
                        begin
                            open_next = 1'b0;
                            closing   = 1'b1;
                            pcnt_next = 3'd2;
                            wp_next   = ptr_add(wp_reg, 3'd3);
                        end
                        else
                        begin
                            wp_next = ptr_add(wp_reg, 3'd1);
                        end
                    end
                    else if (disc_reg)
                    begin
                        left_next = left_reg - 8'd1;
                        if (left_next == 8'd0)
                        begin
                            disc_next = 1'b0;
                        end
                    end
                end
                pfrb_pkg::KIND_TICK:
                begin
                    if (used_now != '0)
                    begin
                        mem_re           = 1'b1;
                        s1_next.tx_valid = 1'b1;
                        rp_next          = ptr_add(rp_reg, 3'd1);
                    end
                end
                default:
                begin
                end
            endcase
        end

        // peak fill updated when an item closes a frame, footer included
        used_new = ring_used(wp_next, rp_next);
        if (closing && (used_new > peak_reg))
        begin
            peak_next = used_new;
        end
        peak_ext = CW'(peak_next);

        s1_next.sending    = (wp_next != rp_next);
        s1_next.drop_total = drop_next;
        s1_next.peak_fill  = (peak_ext > CW'(pfrb_pkg::PEAK_MAX)) ? pfrb_pkg::PEAK_MAX
                                                                  : peak_ext[7:0];
    end

    // memory port selection
    assign mem_we    = busy || first_we;
    assign mem_waddr = busy ? saddr_reg : wp_reg;
    assign mem_wdata = busy ? pend_reg[0] : first_byte;

    // ring memory write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= ring_mem[rp_reg];
        end
    end

    // write sequencer payload
    always_ff @(posedge clk)
    begin
        saddr_reg <= saddr_next;
        for (int i = 0; i < PEND; i++)
        begin
            pend_reg[i] <= pend_next[i];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg     <= '0;
            rp_reg     <= '0;
            sum_reg    <= '0;
            left_reg   <= '0;
            open_reg   <= 1'b0;
            disc_reg   <= 1'b0;
            drop_reg   <= '0;
            peak_reg   <= '0;
            pcnt_reg   <= '0;
            header_reg <= pfrb_pkg::HEADER_RESET;
            footer_reg <= pfrb_pkg::FOOTER_RESET;
        end
        else
        begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            sum_reg  <= sum_next;
            left_reg <= left_next;
            open_reg <= open_next;
            disc_reg <= disc_next;
            drop_reg <= drop_next;
            peak_reg <= peak_next;
            pcnt_reg <= pcnt_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    pfrb_pkg::CFG_HEADER: header_reg <= cfg_data;
                    pfrb_pkg::CFG_FOOTER: footer_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // result stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // read data joins the stage behind the memory
    always_comb
    begin
        s1_join         = s1_reg;
        s1_join.tx_byte = s1_reg.tx_valid ? rdata_reg : 8'd0;
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_reg <= s1_next;
        end
        if (s1_adv && s1_valid_reg)
        begin
            out_reg <= s1_join;
        end
    end

endmodule
